[hdl/cpc_pkg.sv]
// shared constants for the convex plane polygon clipper
// no dependencies; imported by cpc_div, the top level and the testbench
package cpc_pkg;

    localparam int COORD_W      = 32;
    localparam int C_MAX_VERTS  = 32;
    localparam int C_MAX_PLANES = 32;
    localparam int C_FRAC_BITS  = 16;

    // input tuser bit positions
    localparam int TU_MODE = 0;
    localparam int TU_SKIP = 1;

    // item kinds carried in tuser
    localparam logic MODE_PLANE  = 1'b0;
    localparam logic MODE_VERTEX = 1'b1;

endpackage

[hdl/cpc_div.sv]
// restoring divider for the crossing parameter t = num * 2^frac / den
// one quotient bit per cycle; depends on cpc_pkg
module cpc_div #(
    parameter int FRAC_BITS = cpc_pkg::C_FRAC_BITS,
    parameter int NUM_W     = 51
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [NUM_W-1:0]     num,
    input  logic [NUM_W-1:0]     den,
    output logic                 done,
    output logic [FRAC_BITS:0]   quot
);
    import cpc_pkg::*;

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic [NUM_W:0]     rem_reg;
    logic [NUM_W-1:0]   den_reg;
    logic [FRAC_BITS:0] q_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               run_reg;
    logic               done_reg;

    logic [NUM_W:0]     rem_sh;
    logic               ge;

    // the first step compares without a shift to get the integer bit
    always_comb begin
        rem_sh = (cnt_reg == '0) ? rem_reg : {rem_reg[NUM_W-1:0], 1'b0};
        ge     = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                if (cnt_reg == CNT_W'(FRAC_BITS)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            q_reg   <= '0;
        end else if (run_reg) begin
            rem_reg <= ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            q_reg   <= {q_reg[FRAC_BITS-1:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

    a_done_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(run_reg))
        else $error("divider done without a running division");
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg |-> !start)
        else $error("divider restarted while busy");
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (run_reg && cnt_reg != '0) |-> (rem_reg < {1'b0, den_reg}))
        else $error("partial remainder not below divisor");

endmodule

[hdl/convex_plane_polygon_clipper_unit.sv]
// a clip runs a plane step per plane, then multiply and sum steps per vertex and plane; a
// crossing edge waits on the 17-step divider, then multiply, add and, if the current
// vertex is inside, a push step; then each output vertex is read, loaded and sent
// throughput: one load beat per cycle; no beat is taken while a clip runs
// the plane memory and the two-half vertex memory (registered read) set the pace
// reset: aresetn synchronous active low clears counts, overflow flag and handshakes;
// memory contents stay undefined until written, no clearing pass
module convex_plane_polygon_clipper_unit #(
    parameter int MAX_VERTS  = cpc_pkg::C_MAX_VERTS,
    parameter int MAX_PLANES = cpc_pkg::C_MAX_PLANES,
    parameter int FRAC_BITS  = cpc_pkg::C_FRAC_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // coord_x, coord_y, coord_z, plane_offset
    input  logic [1:0]   s_tuser,   // mode, skip_first_plane
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // out_x, out_y, out_z
    output logic [1:0]   m_tuser,   // empty_res, overflow
    output logic         m_tlast
);
    import cpc_pkg::*;

    localparam int CW    = COORD_W;
    localparam int VCW   = $clog2(MAX_VERTS + 1);
    localparam int PCW   = $clog2(MAX_PLANES + 1);
    localparam int VAW   = $clog2(2 * MAX_VERTS);
    localparam int PAW   = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int PRW   = 2 * CW;
    localparam int SHW   = PRW - FRAC_BITS;
    localparam int DW    = SHW + 2;
    localparam int NW    = DW + 1;
    localparam int TW    = FRAC_BITS + 1;
    localparam int LPW   = CW + 1 + TW + 1;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_PLANE = 11'b00000000010,
        S_DMUL  = 11'b00000000100,
        S_DSUM  = 11'b00000001000,
        S_DIV   = 11'b00000010000,
        S_LMUL  = 11'b00000100000,
        S_LADD  = 11'b00001000000,
        S_PUSHC = 11'b00010000000,
        S_OUT   = 11'b00100000000,
        S_OLOAD = 11'b01000000000,
        S_OSEND = 11'b10000000000
    } state_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } vtx_t;

    typedef struct packed {
        logic signed [CW-1:0] d;
        logic signed [CW-1:0] nz;
        logic signed [CW-1:0] ny;
        logic signed [CW-1:0] nx;
    } plane_t;

    // memories
    vtx_t   vmem [2*MAX_VERTS];
    plane_t pmem [MAX_PLANES];
    vtx_t   vrd_reg;
    plane_t prd_reg;

    // control state
    state_t         state_reg, state_next;
    logic [PCW-1:0] pcnt_reg, pcnt_next;
    logic [VCW-1:0] vcnt_reg, vcnt_next;
    logic           ovf_reg, ovf_next;
    logic [PCW-1:0] p_reg, p_next;
    logic           src_reg, src_next;
    logic [VCW-1:0] n_reg, n_next;
    logic [VCW-1:0] m_reg, m_next;
    logic [VCW-1:0] i_reg, i_next;
    logic [VCW-1:0] k_reg, k_next;
    logic           first_reg, first_next;
    logic           ov_reg, ov_next;

    // payload
    vtx_t                 cur_reg, prev_reg;
    logic signed [DW-1:0] dp_reg, dp_next, dc_reg;
    logic signed [PRW-1:0] px_reg, py_reg, pz_reg;
    logic signed [LPW-1:0] lx_reg, ly_reg, lz_reg;
    logic [TW-1:0]        t_reg;
    vtx_t                 od_reg, od_next;
    logic                 olast_reg, olast_next, oempty_reg, oempty_next;

    logic               vwe, pwe;
    logic [VAW-1:0]     vwa, rd_addr;
    logic [VCW-1:0]     rd_off;
    vtx_t               vwd, push_d, lerp_v;
    logic               push_en, adv;
    logic signed [DW-1:0] vdist;
    logic               div_start, div_done;
    logic [NW-1:0]      div_num, div_den;
    logic [TW-1:0]      div_quot;
    logic signed [NW-1:0] diff;
    logic [VAW-1:0]     src_base, dst_base;

    vtx_t   s_vtx;
    plane_t s_pl;

    assign s_vtx = '{x: s_tdata[31:0], y: s_tdata[63:32], z: s_tdata[95:64]};
    assign s_pl  = '{nx: s_tdata[31:0], ny: s_tdata[63:32], nz: s_tdata[95:64],
                     d: s_tdata[127:96]};

    assign src_base = src_reg ? VAW'(MAX_VERTS) : '0;
    assign dst_base = src_reg ? '0 : VAW'(MAX_VERTS);
    assign rd_addr  = src_base + VAW'(rd_off);

    // signed distance of the vertex from the plane, floor-shifted products
    assign vdist = DW'(px_reg >>> FRAC_BITS) + DW'(py_reg >>> FRAC_BITS)
                 + DW'(pz_reg >>> FRAC_BITS) - DW'(prd_reg.d);

    assign diff    = NW'(dp_reg) - NW'(vdist);
    assign div_num = dp_reg[DW-1] ? NW'(-dp_reg) : NW'(dp_reg);
    assign div_den = diff[NW-1] ? NW'(-diff) : NW'(diff);

    assign lerp_v.x = prev_reg.x + CW'(lx_reg >>> FRAC_BITS);
    assign lerp_v.y = prev_reg.y + CW'(ly_reg >>> FRAC_BITS);
    assign lerp_v.z = prev_reg.z + CW'(lz_reg >>> FRAC_BITS);

    cpc_div #(.FRAC_BITS(FRAC_BITS), .NUM_W(NW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_comb begin
        state_next  = state_reg;
        pcnt_next   = pcnt_reg;
        vcnt_next   = vcnt_reg;
        ovf_next    = ovf_reg;
        p_next      = p_reg;
        src_next    = src_reg;
        n_next      = n_reg;
        m_next      = m_reg;
        i_next      = i_reg;
        k_next      = k_reg;
        first_next  = first_reg;
        ov_next     = ov_reg;
        dp_next     = dp_reg;
        od_next     = od_reg;
        olast_next  = olast_reg;
        oempty_next = oempty_reg;
        vwe         = 1'b0;
        pwe         = 1'b0;
        vwa         = dst_base + VAW'(m_reg);
        vwd         = cur_reg;
        push_en     = 1'b0;
        push_d      = cur_reg;
        adv         = 1'b0;
        rd_off      = i_reg;
        div_start   = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser[TU_MODE] == MODE_PLANE) begin
                        if (pcnt_reg < PCW'(MAX_PLANES)) begin
                            pwe       = 1'b1;
                            pcnt_next = pcnt_reg + 1'b1;
                        end
                    end else begin
                        if (vcnt_reg < VCW'(MAX_VERTS)) begin
                            vwe       = 1'b1;
                            vwa       = VAW'(vcnt_reg);
                            vwd       = s_vtx;
                            vcnt_next = vcnt_reg + 1'b1;
                        end else begin
                            ovf_next = 1'b1;
                        end
                        if (s_tlast) begin
                            p_next     = s_tuser[TU_SKIP] ? PCW'(1) : '0;
                            src_next   = 1'b0;
                            n_next     = vcnt_next;
                            m_next     = '0;
                            state_next = S_PLANE;
                        end
                    end
                end
            end
            S_PLANE: begin
                if (p_reg < pcnt_reg && n_reg != '0) begin
                    rd_off     = n_reg - 1'b1;
                    first_next = 1'b1;
                    i_next     = '0;
                    state_next = S_DMUL;
                end else begin
                    k_next     = '0;
                    state_next = S_OUT;
                end
            end
            S_DMUL: state_next = S_DSUM;
            S_DSUM: begin
                if (first_reg) begin
                    // wrap-around predecessor done, now the first vertex
                    first_next = 1'b0;
                    dp_next    = vdist;
                    rd_off     = '0;
                    state_next = S_DMUL;
                end else if (vdist[DW-1] != dp_reg[DW-1]) begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end else begin
                    push_en = !vdist[DW-1];
                    adv     = 1'b1;
                end
            end
            S_DIV: begin
                if (div_done) state_next = S_LMUL;
            end
            S_LMUL: state_next = S_LADD;
            S_LADD: begin
                push_en = 1'b1;
                push_d  = lerp_v;
                if (!dc_reg[DW-1]) begin
                    state_next = S_PUSHC;
                end else begin
                    adv = 1'b1;
                end
            end
            S_PUSHC: begin
                push_en = 1'b1;
                adv     = 1'b1;
            end
            S_OUT: begin
                if (n_reg == '0) begin
                    od_next     = '0;
                    oempty_next = 1'b1;
                    olast_next  = 1'b1;
                    ov_next     = 1'b1;
                    state_next  = S_OSEND;
                end else begin
                    rd_off     = k_reg;
                    state_next = S_OLOAD;
                end
            end
            S_OLOAD: begin
                od_next     = vrd_reg;
                oempty_next = 1'b0;
                olast_next  = (k_reg + 1'b1 == n_reg);
                ov_next     = 1'b1;
                state_next  = S_OSEND;
            end
            S_OSEND: begin
                if (m_tready) begin
                    ov_next = 1'b0;
                    if (olast_reg) begin
                        pcnt_next  = '0;
                        vcnt_next  = '0;
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_OUT;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase

        // output halves never overlap the half being read
        if (push_en) begin
            vwd = push_d;
            if (m_reg < VCW'(MAX_VERTS)) begin
                vwe    = 1'b1;
                m_next = m_reg + 1'b1;
            end else begin
                ovf_next = 1'b1;
            end
        end

        if (adv) begin
            dp_next = (state_reg == S_DSUM) ? vdist : dc_reg;
            if (i_reg + 1'b1 == n_reg) begin
                src_next   = !src_reg;
                n_next     = m_next;
                m_next     = '0;
                p_next     = p_reg + 1'b1;
                state_next = S_PLANE;
            end else begin
                i_next     = i_reg + 1'b1;
                rd_off     = i_reg + 1'b1;
                state_next = S_DMUL;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pcnt_reg  <= '0;
            vcnt_reg  <= '0;
            ovf_reg   <= 1'b0;
            ov_reg    <= 1'b0;
            p_reg     <= '0;
            src_reg   <= 1'b0;
            n_reg     <= '0;
            m_reg     <= '0;
            i_reg     <= '0;
            k_reg     <= '0;
            first_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pcnt_reg  <= pcnt_next;
            vcnt_reg  <= vcnt_next;
            ovf_reg   <= ovf_next;
            ov_reg    <= ov_next;
            p_reg     <= p_next;
            src_reg   <= src_next;
            n_reg     <= n_next;
            m_reg     <= m_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (vwe) vmem[vwa] <= vwd;
        vrd_reg <= vmem[rd_addr];
        if (pwe) pmem[pcnt_reg[PAW-1:0]] <= s_pl;
        prd_reg <= pmem[p_next[PAW-1:0]];
    end

    always_ff @(posedge aclk) begin
        px_reg <= PRW'(prd_reg.nx) * PRW'(vrd_reg.x);
        py_reg <= PRW'(prd_reg.ny) * PRW'(vrd_reg.y);
        pz_reg <= PRW'(prd_reg.nz) * PRW'(vrd_reg.z);
        lx_reg <= LPW'(cur_reg.x - LPW'(prev_reg.x)) * LPW'($signed({1'b0, t_reg}));
        ly_reg <= LPW'(cur_reg.y - LPW'(prev_reg.y)) * LPW'($signed({1'b0, t_reg}));
        lz_reg <= LPW'(cur_reg.z - LPW'(prev_reg.z)) * LPW'($signed({1'b0, t_reg}));
        if (state_reg == S_DMUL) cur_reg <= vrd_reg;
        if (state_reg == S_DSUM) dc_reg <= vdist;
        if (adv || (state_reg == S_DSUM && first_reg)) prev_reg <= cur_reg;
        if (div_done) t_reg <= div_quot;
        dp_reg     <= dp_next;
        od_reg     <= od_next;
        olast_reg  <= olast_next;
        oempty_reg <= oempty_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata  = {od_reg.z, od_reg.y, od_reg.x};
    assign m_tuser  = {ovf_reg, oempty_reg};
    assign m_tlast  = olast_reg;

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("load and result beats overlap");
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && oempty_reg) |-> olast_reg)
        else $error("empty result not marked final");
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_reg <= VCW'(MAX_VERTS) && n_reg <= VCW'(MAX_VERTS))
        else $error("vertex list past buffer size");
    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DIV)
        else $error("quotient arrived outside the divide step");

endmodule

[verif/convex_plane_polygon_clipper_unit_tb.sv]
// self-checking testbench for convex_plane_polygon_clipper_unit: loads planes and
// polygons, predicts the clipped vertex stream in fixed point and checks every beat
// depends on cpc_pkg and the clipper rtl only
module convex_plane_polygon_clipper_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cpc_pkg::*;

    localparam int FB = C_FRAC_BITS;
    localparam int ONE = 1 << FB;

    typedef struct {
        logic        mode;
        int          x, y, z, d;
        bit          skip, fin;
        bit          typed;     // expected result written in the row
        int          ex, ey, ez;
        bit          e_empty;
    } load_item_t;

    typedef struct {
        int x, y, z;
        bit fin, empty, ovf;
    } clip_vert_t;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         s_tlast = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [95:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    convex_plane_polygon_clipper_unit DUT (.*);

    // predictor state
    int         pl_nx[C_MAX_PLANES], pl_ny[C_MAX_PLANES], pl_nz[C_MAX_PLANES];
    int         pl_d[C_MAX_PLANES];
    int         vx[2*C_MAX_VERTS], vy[2*C_MAX_VERTS], vz[2*C_MAX_VERTS];
    int         n_planes, n_verts;
    bit         ovf_seen;
    clip_vert_t clipped_q[$];

    int  errors = 0;
    int  items_sent = 0;
    int  sender_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_req = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic longint plane_dist(int p, int vi);
        longint a, b, c;
        a = (longint'(pl_nx[p]) * longint'(vx[vi])) >>> FB;
        b = (longint'(pl_ny[p]) * longint'(vy[vi])) >>> FB;
        c = (longint'(pl_nz[p]) * longint'(vz[vi])) >>> FB;
        return a + b + c - longint'(pl_d[p]);
    endfunction

    function automatic longint cross_frac(longint num, longint den);
        longint unsigned n, d, q, r;
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        q = 0;
        r = n;
        if (d == 0) return 0;
        if (r >= d) begin
            q = 1;
            r -= d;
        end
        for (int k = 0; k < FB; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r -= d;
                q |= 1;
            end
        end
        return longint'(q);
    endfunction

    function automatic int lerp(int a, int b, longint t);
        longint delta;
        delta = longint'(b) - longint'(a);
        return int'(longint'(a) + ((delta * t) >>> FB));
    endfunction

    function automatic void store_vert(int base, ref int m, input int x, int y, int z);
        if (m < C_MAX_VERTS) begin
            vx[base + m] = x;
            vy[base + m] = y;
            vz[base + m] = z;
            m++;
        end else begin
            ovf_seen = 1;
        end
    endfunction

    // returns the clip results caused by one accepted beat
    function automatic void clip_predict(load_item_t it, ref clip_vert_t res[$]);
        int src, dst, n, m, ci, pi, tmp;
        longint dc, dp, t;
        clip_vert_t r;
        res.delete();
        if (it.mode == MODE_PLANE) begin
            if (n_planes < C_MAX_PLANES) begin
                pl_nx[n_planes] = it.x;
                pl_ny[n_planes] = it.y;
                pl_nz[n_planes] = it.z;
                pl_d[n_planes]  = it.d;
                n_planes++;
            end
            return;
        end
        store_vert(0, n_verts, it.x, it.y, it.z);
        if (!it.fin) return;
        src = 0;
        dst = C_MAX_VERTS;
        n = n_verts;
        for (int p = it.skip ? 1 : 0; p < n_planes && n > 0; p++) begin
            m = 0;
            for (int i = 0; i < n; i++) begin
                ci = src + i;
                pi = src + (i == 0 ? n - 1 : i - 1);
                dc = plane_dist(p, ci);
                dp = plane_dist(p, pi);
                if ((dc >= 0) != (dp >= 0)) begin
                    t = cross_frac(dp, dp - dc);
                    store_vert(dst, m, lerp(vx[pi], vx[ci], t), lerp(vy[pi], vy[ci], t),
                               lerp(vz[pi], vz[ci], t));
                end
                if (dc >= 0) store_vert(dst, m, vx[ci], vy[ci], vz[ci]);
            end
            tmp = src;
            src = dst;
            dst = tmp;
            n = m;
        end
        if (n == 0) begin
            r = '{0, 0, 0, 1, 1, ovf_seen};
            res.push_back(r);
        end else begin
            for (int k = 0; k < n; k++) begin
                r = '{vx[src+k], vy[src+k], vz[src+k], k + 1 == n, 0, ovf_seen};
                res.push_back(r);
            end
        end
        n_planes = 0;
        n_verts = 0;
        ovf_seen = 0;
    endfunction

    // drive one beat from a falling edge, returns at the falling edge after acceptance
    task automatic send_beat(load_item_t it);
        clip_vert_t res[$];
        bit taken;
        if ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid = 0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid = 1;
        s_tdata  = {it.d, it.z, it.y, it.x};
        s_tuser  = '0;
        s_tuser[TU_MODE] = it.mode;
        s_tuser[TU_SKIP] = it.skip;
        s_tlast  = it.fin;
        do begin
            @(posedge aclk);
            taken = s_tready;
            @(negedge aclk);
        end while (!taken);
        items_sent++;
        clip_predict(it, res);
        if (it.typed && res.size() == 1)
            res[0] = '{it.ex, it.ey, it.ez, 1, it.e_empty, res[0].ovf};
        foreach (res[k]) clipped_q.push_back(res[k]);
    endtask

    function automatic load_item_t mk(logic mode, int x, int y, int z, int d,
                                      bit skip, bit fin);
        load_item_t it;
        it = '{mode, x, y, z, d, skip, fin, 0, 0, 0, 0, 0};
        return it;
    endfunction

    function automatic load_item_t mk_typed(int x, int y, int z, bit skip,
                                            int ex, int ey, int ez, bit e_empty);
        load_item_t it;
        it = '{MODE_VERTEX, x, y, z, 0, skip, 1, 1, ex, ey, ez, e_empty};
        return it;
    endfunction

    function automatic int rnd_coord(bit wide);
        if (wide) return int'($urandom);
        return int'($urandom_range(0, 8*ONE)) - 4*ONE;
    endfunction

    // one well-formed clip: planes, then a polygon ending in a last beat
    task automatic random_clip();
        int np, nv;
        bit wide;
        load_item_t it;
        wide = $urandom_range(9) == 0;
        np = $urandom_range(19) == 0 ? $urandom_range(30, 34) : $urandom_range(0, 4);
        nv = $urandom_range(11) == 0 ? $urandom_range(30, 35) : $urandom_range(1, 8);
        for (int i = 0; i < np; i++) begin
            it = mk(MODE_PLANE, rnd_coord(wide) >>> 2, rnd_coord(wide) >>> 2,
                    rnd_coord(wide) >>> 2, rnd_coord(wide) >>> 1,
                    $urandom_range(1), $urandom_range(7) == 0);
            send_beat(it);
        end
        for (int i = 0; i < nv; i++) begin
            it = mk(MODE_VERTEX, rnd_coord(wide), rnd_coord(wide), rnd_coord(wide),
                    int'($urandom), $urandom_range(1), i == nv - 1);
            send_beat(it);
        end
    endtask

    task automatic wait_drained();
        while (clipped_q.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    // result side: check at the rising edge, pick ready at the falling edge
    initial begin
        int hold;
        clip_vert_t e;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (clipped_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected beat %h last %b user %b", m_tdata, m_tlast,
                                 m_tuser);
                end else begin
                    e = clipped_q.pop_front();
                    if (m_tdata !== {e.z, e.y, e.x} || m_tlast !== e.fin ||
                        m_tuser[0] !== e.empty || m_tuser[1] !== e.ovf) begin
                        errors++;
                        if (errors <= 10)
                            $display("beat mismatch: exp %h %h %h last %b empty %b ovf %b, got %h last %b user %b",
                                     e.x, e.y, e.z, e.fin, e.empty, e.ovf,
                                     m_tdata, m_tlast, m_tuser);
                    end
                end
            end
            @(negedge aclk);
            if (hold_req && hold == 0) hold = 400;
            if (hold > 0) begin
                hold--;
                m_tready = 0;
            end else begin
                m_tready = $urandom_range(99) >= recv_stall_pct;
            end
        end
    end

    initial begin
        #10ms;
        $display("convex_plane_polygon_clipper_unit: mismatch");
        $finish;
    end

    initial begin
        load_item_t dir[$];
        n_planes = 0;
        n_verts = 0;
        ovf_seen = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // no planes: polygon comes back unchanged
        dir.push_back(mk_typed(ONE, 2*ONE, 3*ONE, 0, ONE, 2*ONE, 3*ONE, 0));
        // plane that rejects every point gives the empty result
        dir.push_back(mk(MODE_PLANE, 0, 0, 0, 1, 0, 0));
        dir.push_back(mk(MODE_VERTEX, ONE, ONE, ONE, 0, 1, 0));
        dir.push_back(mk_typed(-ONE, ONE, 0, 0, 0, 0, 0, 1));
        // x >= 0 half-space across a triangle whose first vertex lies outside, so both of its edges cross
        dir.push_back(mk(MODE_PLANE, ONE, 0, 0, 0, 0, 0));
        dir.push_back(mk(MODE_VERTEX, -ONE, 0, 0, 0, 0, 0));
        dir.push_back(mk(MODE_VERTEX, 3*ONE, ONE, 0, 0, 0, 0));
        dir.push_back(mk(MODE_VERTEX, ONE, -3*ONE, ONE, 0, 0, 1));
        // near plane skipped: rejecting plane 0 has no effect
        dir.push_back(mk(MODE_PLANE, 0, 0, 0, 1, 0, 0));
        dir.push_back(mk(MODE_PLANE, 0, ONE, 0, -8*ONE, 0, 1));  // last on a plane
        dir.push_back(mk(MODE_VERTEX, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(MODE_VERTEX, ONE, 0, 0, 0, 0, 0));
        dir.push_back(mk(MODE_VERTEX, 0, ONE, 0, 0, 1, 1));
        // extremes of every field
        dir.push_back(mk(MODE_PLANE, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                         32'h80000000, 1, 0));
        dir.push_back(mk(MODE_PLANE, 32'h80000000, 32'h7fffffff, -1, 32'h7fffffff, 0, 0));
        dir.push_back(mk(MODE_VERTEX, 32'h80000000, 32'h7fffffff, 32'h80000000,
                         32'hffffffff, 0, 0));
        dir.push_back(mk(MODE_VERTEX, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0));
        dir.push_back(mk(MODE_VERTEX, -1, -1, 0, 32'h7fffffff, 0, 1));
        // single vertex with a plane it lies on
        dir.push_back(mk(MODE_PLANE, 0, 0, ONE, 0, 0, 0));
        dir.push_back(mk(MODE_VERTEX, 5, -7, 0, 0, 0, 1));
        foreach (dir[i]) send_beat(dir[i]);
        s_tvalid = 0;
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct = (ph == 1) ? 74 : (ph == 3) ? 26 : 0;
            recv_stall_pct  = (ph == 2) ? 74 : (ph == 3) ? 26 : 0;
            if (ph == 2) hold_req = 1;
            for (int c = 0; c < 2; c++) begin
                if ($urandom_range(3) == 0) begin
                    // stray loads that end no polygon
                    send_beat(mk($urandom_range(1), int'($urandom), int'($urandom),
                                 int'($urandom), int'($urandom), $urandom_range(1), 0));
                end
                random_clip();
                if (ph == 2 && c == 0) hold_req = 0;
            end
            s_tvalid = 0;
            wait_drained();
        end
        // top up to the planned number of load beats
        while (items_sent < 130) random_clip();
        s_tvalid = 0;
        wait_drained();
        repeat (200) @(posedge aclk);
        if (errors == 0 && clipped_q.size() == 0) begin
            $display("convex_plane_polygon_clipper_unit: match");
        end else begin
            $display("convex_plane_polygon_clipper_unit: mismatch");
        end
        $finish;
    end

endmodule
